// ----- rtl/bcsf_pkg.sv -----
`default_nettype none
package bcsf_pkg;

  // Failed-read markers
  localparam logic [15:0] FAIL_WORD = 16'hFFFF;
  localparam logic [7:0]  FAIL_BYTE = 8'hFF;

  // Voltage breakpoints in mV
  localparam logic [15:0] V_FULL = 16'd4200;
  localparam logic [15:0] V_BP3  = 16'd4000;
  localparam logic [15:0] V_BP2  = 16'd3800;
  localparam logic [15:0] V_BP1  = 16'd3600;
  localparam logic [15:0] V_EMPTY = 16'd3300;

  // Charge limits in percent
  localparam logic [7:0] PCT_FULL    = 8'd100;
  localparam logic [7:0] PCT_TRUST   = 8'd98;
  localparam logic [7:0] PCT_CREEP   = 8'd99;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CACHE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_BAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT   = 3'd3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef struct packed {
    logic       hold_cache;
    logic [9:0] noise_band_ma;
    logic [9:0] charge_threshold_ma;
    logic [6:0] jump_limit_pct;
  } cfg_t;

  typedef struct packed {
    logic [15:0] flags_raw;
    logic [7:0]  charge_raw;
    logic [15:0] cur_raw;
    logic [15:0] voltage_raw;
  } sample_t;

  typedef struct packed {
    logic               cache_valid;
    logic [15:0]        last_voltage;
    logic signed [15:0] last_current;
    logic [6:0]         last_percent;
    logic               last_charging;
  } state_t;

  // Piecewise-linear charge estimate from voltage, constant divisors by reciprocal
  function automatic logic [6:0] volt_est(logic [15:0] v);
    logic [15:0] d;
    logic [10:0] x;
    logic [7:0]  y;
    logic [16:0] p;
    logic [6:0]  r;
    d = '0;
    x = '0;
    y = '0;
    p = '0;
    if (v >= V_FULL) begin
      r = 7'd100;
    end else if (v >= V_BP3) begin
      d = v - V_BP3;
      r = 7'd75 + 7'(d[7:3]);
    end else if (v >= V_BP2) begin
      d = v - V_BP2;
      x = 11'(d[7:0]) * 11'd7;
      y = x[10:3];
      p = 17'(y) * 17'd205;
      r = 7'd40 + 7'(p[16:10]);
    end else if (v >= V_BP1) begin
      d = v - V_BP1;
      x = 11'(d[7:0]) * 11'd3;
      y = x[9:2];
      p = 17'(y) * 17'd205;
      r = 7'd10 + 7'(p[16:10]);
    end else if (v >= V_EMPTY) begin
      d = v - V_EMPTY;
      y = d[8:1];
      p = 17'(y) * 17'd274;
      r = 7'(p[16:12]);
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bcsf_cfg.sv -----
`default_nettype none
module bcsf_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [bcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcsf_pkg::CFG_DATA_W-1:0] cfg_data,
  output bcsf_pkg::cfg_t                      cfg
);
  import bcsf_pkg::*;

  // Write one register per accepted word; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_cache          <= 1'b0;
      cfg.noise_band_ma       <= 10'd10;
      cfg.charge_threshold_ma <= 10'd10;
      cfg.jump_limit_pct      <= 7'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HOLD_CACHE: cfg.hold_cache          <= cfg_data[0];
        CFG_NOISE_BAND: cfg.noise_band_ma       <= cfg_data[9:0];
        CFG_CHARGE_THR: cfg.charge_threshold_ma <= cfg_data[9:0];
        CFG_JUMP_LIMIT: cfg.jump_limit_pct      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bcsf_calc.sv -----
`default_nettype none
module bcsf_calc (
  input  wire bcsf_pkg::sample_t smp,
  input  wire bcsf_pkg::cfg_t    cfg,
  input  wire bcsf_pkg::state_t  st,
  output bcsf_pkg::state_t       st_next
);
  import bcsf_pkg::*;

  logic               v_ok, c_ok, q_ok, f_ok;
  logic [2:0]         good;
  logic signed [16:0] craw_x, thr_x, cur_x;
  logic signed [15:0] cur_sel, cur_fin;
  logic [16:0]        mag;
  logic               hint, chg;
  logic [15:0]        volt;
  logic [6:0]         vest;
  logic [7:0]         last8, lastp1, pct, tgt, diff;

  always_comb begin
    // Read-quality checks
    v_ok = smp.voltage_raw != FAIL_WORD;
    c_ok = smp.cur_raw     != FAIL_WORD;
    q_ok = smp.charge_raw  != FAIL_BYTE;
    f_ok = smp.flags_raw   != FAIL_WORD;
    good = 3'(v_ok) + 3'(c_ok) + 3'(q_ok) + 3'(f_ok);

    craw_x = $signed({smp.cur_raw[15], smp.cur_raw});
    thr_x  = $signed({7'd0, cfg.charge_threshold_ma});
    hint   = (f_ok && !smp.flags_raw[0]) || (c_ok && (craw_x > thr_x));

    // Substitute failed voltage and current, zero current inside noise band
    volt    = v_ok ? smp.voltage_raw : st.last_voltage;
    cur_sel = c_ok ? $signed(smp.cur_raw) : st.last_current;
    cur_x   = $signed({cur_sel[15], cur_sel});
    mag     = cur_x[16] ? 17'(-cur_x) : 17'(cur_x);
    cur_fin = (mag < {7'd0, cfg.noise_band_ma}) ? 16'sd0 : cur_sel;

    // Choose charge value
    vest   = volt_est(smp.voltage_raw);
    last8  = {1'b0, st.last_percent};
    lastp1 = last8 + 8'd1;
    tgt    = '0;
    if (smp.charge_raw <= PCT_FULL) begin
      pct = smp.charge_raw;
      if (smp.charge_raw == PCT_FULL) begin
        if (v_ok && ({1'b0, vest} < PCT_TRUST)) begin
          pct = {1'b0, vest};
        end else if (hint) begin
          tgt = v_ok ? {1'b0, vest} : PCT_FULL;
          if (st.cache_valid && (tgt < lastp1)) tgt = lastp1;
          if (tgt > PCT_CREEP) tgt = PCT_CREEP;
          pct = tgt;
        end
      end
    end else if (v_ok) begin
      pct = {1'b0, vest};
    end else begin
      pct = last8;
    end

    // Smooth small changes to one step per sample
    diff = (pct > last8) ? (pct - last8) : (last8 - pct);
    if (st.cache_valid && (diff != 8'd0) && (diff <= {1'b0, cfg.jump_limit_pct})) begin
      pct = (pct > last8) ? lastp1 : (last8 - 8'd1);
    end

    // Charging direction
    if (f_ok || c_ok) begin
      chg = (f_ok && !smp.flags_raw[0]) ||
            (c_ok && ($signed({cur_fin[15], cur_fin}) > thr_x));
    end else begin
      chg = st.last_charging;
    end

    // Keep cache on hold or too few good reads
    if (cfg.hold_cache || (good < 3'd2)) begin
      st_next = st;
    end else begin
      st_next.cache_valid   = 1'b1;
      st_next.last_voltage  = volt;
      st_next.last_current  = cur_fin;
      st_next.last_percent  = pct[6:0];
      st_next.last_charging = chg;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/battery_charge_state_filter_core.sv -----
// Channel  | Dir | Handshake                  | Payload
// s_axis   | in  | s_axis_tvalid/tready       | sample word, 56 bits
// m_axis   | out | m_axis_tvalid/tready       | report word, 48 bits
// cfg      | in  | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One word per cycle while the output drains; input register, then result register.
// The cache update loop is a single pass through bcsf_calc between those registers.
// Synchronous active-high reset clears valid flags and cache state, presets config.
// A stalled result holds in the result register; a new word moves up behind it
// only while the result can drain, and s_axis_tready drops when both are full.
`default_nettype none
module battery_charge_state_filter_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // [15:0] voltage_raw, [31:16] cur_raw, [39:32] charge_raw, [55:40] flags_raw
  input  wire logic [55:0]                    s_axis_tdata,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] report_ok, [16:1] rep_mv, [32:17] rep_ma, [39:33] percent,
  // [40] charging, [47:41] zero
  output      logic [47:0]                    m_axis_tdata,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcsf_pkg::*;

  cfg_t    cfg;
  sample_t smp;
  logic    smp_vld;
  state_t  st, st_next;
  logic    fire;

  assign cfg_ready = 1'b1;

  bcsf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcsf_calc u_calc (
    .smp     (smp),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next)
  );

  // Advance when the result register is empty or draining
  assign fire          = smp_vld && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !smp_vld || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_vld <= 1'b0;
    end else if (s_axis_tready) begin
      smp_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      smp <= s_axis_tdata;
    end
  end

  // Cache state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (st_next.cache_valid) begin
        m_axis_tdata <= {7'd0, st_next.last_charging, st_next.last_percent,
                         st_next.last_current, st_next.last_voltage, 1'b1};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bcsf_chk.sv -----
`default_nettype none
module bcsf_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

  // Empty report carries all-zero fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[47:1] == 47'd0))
    else $error("empty report with nonzero fields");

  // Percent in range and padding clear
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[39:33] <= 7'd100) && (m_axis_tdata[47:41] == 7'd0)))
    else $error("percent out of range or padding set");

  // Once a report is available it stays available
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tdata[0]) |=>
      !(m_axis_tvalid && !m_axis_tdata[0]))
    else $error("report lost after cache became valid");

  // Input side never stalls while the output is free
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid && !$past(rst)) |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind battery_charge_state_filter_core bcsf_chk u_bcsf_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
